// File: design/pfvd_pkg.sv
// Package: shared types and constants for the protobuf field value decoder.
package pfvd_pkg;

	typedef enum logic [5:0] {
		PH_IDLE    = 6'b000001,
		PH_VARINT  = 6'b000010,
		PH_FIX64   = 6'b000100,
		PH_LENVAR  = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_FIX32   = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TRUNC    = 2'd1,
		ST_OVERLONG = 2'd2,
		ST_BADTYPE  = 2'd3
	} status_t;

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_FIX64  = 3'd1;
	localparam logic [2:0] WT_LEN    = 3'd2;
	localparam logic [2:0] WT_FIX32  = 3'd5;

	localparam logic       MODE_DATA = 1'b0;
	localparam logic       MODE_EOB  = 1'b1;

	localparam logic [3:0] VARINT_LAST_CNT = 4'd9;
	localparam logic [3:0] FIX64_BYTES     = 4'd8;
	localparam logic [3:0] FIX32_BYTES     = 4'd4;

	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [2:0]  wire_type;
		logic [63:0] value;
	} result_t;

endpackage

// File: design/pfvd_core.sv
// Decoder state and per-word next-state logic for one field value.
module pfvd_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  mode,
	input  logic [7:0]            data_byte,
	input  logic [2:0]            wire_type,
	output pfvd_pkg::result_t     res
);

	pfvd_pkg::phase_t phase_q, phase_d, ph;
	logic [63:0] acc_q, acc_d, acc_base, vacc, facc;
	logic [3:0]  cnt_q, cnt_d, cnt_base, cnt_inc;
	logic [63:0] rem_q, rem_d, rem_dec;
	logic [2:0]  hwt_q, hwt_d;
	logic [5:0]  vshift;
	logic        start_ok;

	always_comb begin
		res      = '0;
		phase_d  = phase_q;
		acc_d    = acc_q;
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		hwt_d    = hwt_q;
		ph       = phase_q;
		acc_base = acc_q;
		cnt_base = cnt_q;
		start_ok = 1'b1;

		if (phase_q == pfvd_pkg::PH_IDLE) begin
			acc_base = '0;
			cnt_base = '0;
			case (wire_type)
				pfvd_pkg::WT_VARINT: ph = pfvd_pkg::PH_VARINT;
				pfvd_pkg::WT_FIX64:  ph = pfvd_pkg::PH_FIX64;
				pfvd_pkg::WT_LEN:    ph = pfvd_pkg::PH_LENVAR;
				pfvd_pkg::WT_FIX32:  ph = pfvd_pkg::PH_FIX32;
				default:             start_ok = 1'b0;
			endcase
		end

		vshift  = 6'(({3'b000, cnt_base} << 3) - {3'b000, cnt_base});
		vacc    = acc_base | ({57'b0, data_byte[6:0]} << vshift);
		facc    = acc_base | ({56'b0, data_byte} << {cnt_base[2:0], 3'b000});
		cnt_inc = cnt_base + 4'd1;
		rem_dec = rem_q - 64'd1;

		if (mode == pfvd_pkg::MODE_EOB) begin
			if (phase_q != pfvd_pkg::PH_IDLE) begin
				res.valid     = 1'b1;
				res.status    = pfvd_pkg::ST_TRUNC;
				res.wire_type = hwt_q;
				phase_d       = pfvd_pkg::PH_IDLE;
			end
		end else if (!start_ok) begin
			res.valid     = 1'b1;
			res.status    = pfvd_pkg::ST_BADTYPE;
			res.wire_type = wire_type;
		end else begin
			if (phase_q == pfvd_pkg::PH_IDLE) begin
				hwt_d = wire_type;
			end
			res.wire_type = hwt_d;
			case (ph)
				pfvd_pkg::PH_VARINT, pfvd_pkg::PH_LENVAR: begin
					if (!data_byte[7]) begin
						if (ph == pfvd_pkg::PH_LENVAR && vacc != 64'd0) begin
							phase_d = pfvd_pkg::PH_PAYLOAD;
							acc_d   = vacc;
							rem_d   = vacc;
						end else begin
							res.valid  = 1'b1;
							res.status = pfvd_pkg::ST_OK;
							res.value  = vacc;
							phase_d    = pfvd_pkg::PH_IDLE;
						end
					end else if (cnt_base == pfvd_pkg::VARINT_LAST_CNT) begin
						res.valid  = 1'b1;
						res.status = pfvd_pkg::ST_OVERLONG;
						phase_d    = pfvd_pkg::PH_IDLE;
					end else begin
						phase_d = ph;
						acc_d   = vacc;
						cnt_d   = cnt_inc;
					end
				end
				pfvd_pkg::PH_FIX64, pfvd_pkg::PH_FIX32: begin
					if (cnt_inc == ((ph == pfvd_pkg::PH_FIX64) ?
							pfvd_pkg::FIX64_BYTES : pfvd_pkg::FIX32_BYTES)) begin
						res.valid  = 1'b1;
						res.status = pfvd_pkg::ST_OK;
						res.value  = facc;
						phase_d    = pfvd_pkg::PH_IDLE;
					end else begin
						phase_d = ph;
						acc_d   = facc;
						cnt_d   = cnt_inc;
					end
				end
				pfvd_pkg::PH_PAYLOAD: begin
					rem_d = rem_dec;
					if (rem_dec == 64'd0) begin
						res.valid  = 1'b1;
						res.status = pfvd_pkg::ST_OK;
						res.value  = acc_q;
						phase_d    = pfvd_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_d = pfvd_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pfvd_pkg::PH_IDLE;
			acc_q   <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			hwt_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			rem_q   <= rem_d;
			hwt_q   <= hwt_d;
		end
	end

endmodule

// File: design/protobuf_field_value_decoder_unit.sv
// Top level: protobuf field value decoder with input and result registers.
// A word's result is registered in the result register when the word steps the decoder.
// Throughput: one word per cycle while the input does not stall.
// Input stalls only while a word waiting in the input register owes a result
// and the result register is full and stalled.
// Reset (arst_n low, asynchronous): decoder idle, both registers empty.
module protobuf_field_value_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	input  logic [2:0]  wire_type,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [2:0]  field_wire_type,
	output logic [63:0] field_value
);

	logic              valid_s1;
	logic              mode_s1;
	logic [7:0]        byte_s1;
	logic [2:0]        wt_s1;
	logic              step;
	logic              out_free;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [2:0]        wt_q;
	logic [63:0]       value_q;
	pfvd_pkg::result_t res;

	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && (!res.valid || out_free);
	assign in_stall = valid_s1 && !step;

	pfvd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.mode      (mode_s1),
		.data_byte (byte_s1),
		.wire_type (wt_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			mode_s1 <= mode;
			byte_s1 <= data_byte;
			wt_s1   <= wire_type;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && res.valid) begin
			status_q <= res.status;
			wt_q     <= res.wire_type;
			value_q  <= res.value;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign field_wire_type = wt_q;
	assign field_value     = value_q;

endmodule
